// ===== rtl/wsfr_pkg.sv =====
`default_nettype none
package wsfr_pkg;

    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXT     = 3'd2,
        PH_MASK    = 3'd3,
        PH_PAYLOAD = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        LINK_OPEN    = 2'd0,
        LINK_CLOSING = 2'd1,
        LINK_CLOSED  = 2'd2
    } link_t;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_TICK  = 2'd1;
    localparam logic [1:0] KIND_CLOSE = 2'd2;

    localparam logic [1:0] CLS_NONE  = 2'd0;
    localparam logic [1:0] CLS_DATA  = 2'd1;
    localparam logic [1:0] CLS_PING  = 2'd2;
    localparam logic [1:0] CLS_OTHER = 2'd3;

    localparam logic [3:0] OP_CONT  = 4'd0;
    localparam logic [3:0] OP_TEXT  = 4'd1;
    localparam logic [3:0] OP_BIN   = 4'd2;
    localparam logic [3:0] OP_CLOSE = 4'd8;
    localparam logic [3:0] OP_PING  = 4'd9;

    localparam logic [6:0] LEN_CODE_16  = 7'd126;
    localparam logic [6:0] LEN_CODE_64  = 7'd127;
    localparam logic [6:0] MAX_CTRL_LEN = 7'd125;
    localparam logic [6:0] LONG_MARK    = 7'd126;

    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES   = 4'd4;

    localparam logic [7:0]  MISSED_RESET = 8'd3;
    localparam logic [31:0] GAP_RESET    = 32'd1000;

    localparam logic CFG_MISSED = 1'b0;
    localparam logic CFG_GAP    = 1'b1;

    typedef struct packed {
        logic [1:0] byte_class;
        logic [7:0] payload_byte;
        logic       frame_end;
        logic [3:0] frame_opcode;
        logic       want_ping;
        logic       want_pong;
        logic       want_close;
        logic       link_closed;
        logic [1:0] link_state;
    } res_t;

endpackage
`default_nettype wire

// ===== rtl/wsfr_core.sv =====
`default_nettype none
module wsfr_core (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         en,
    input  wire logic [1:0]   kind,
    input  wire logic [7:0]   rx_byte,
    input  wire logic [31:0]  now_time,
    input  wire logic [7:0]   max_missed,
    input  wire logic [31:0]  pong_gap,
    output wsfr_pkg::res_t    res
);

    wsfr_pkg::phase_t phase_reg, phase_next;
    wsfr_pkg::link_t  link_reg, link_next;
    logic [3:0]  fbc_reg, fbc_next;
    logic        fin_reg, fin_next;
    logic [3:0]  op_reg, op_next;
    logic        mpres_reg, mpres_next;
    logic [31:0] key_reg, key_next;
    logic [63:0] left_reg, left_next;
    logic [6:0]  slen_reg, slen_next;
    logic [1:0]  midx_reg, midx_next;
    logic [7:0]  missed_reg, missed_next;
    logic [31:0] pong_t_reg, pong_t_next;
    logic        pong_sent_reg, pong_sent_next;

    logic        finish;
    logic        hdr_done;
    logic [63:0] hdr_len;
    logic [3:0]  fbc_inc;
    logic [63:0] left_shift;
    logic [63:0] left_dec;
    logic [31:0] diff;
    logic [7:0]  key_byte;
    logic        ext_full;

    always_comb begin
        phase_next     = phase_reg;
        link_next      = link_reg;
        fbc_next       = fbc_reg;
        fin_next       = fin_reg;
        op_next        = op_reg;
        mpres_next     = mpres_reg;
        key_next       = key_reg;
        left_next      = left_reg;
        slen_next      = slen_reg;
        midx_next      = midx_reg;
        missed_next    = missed_reg;
        pong_t_next    = pong_t_reg;
        pong_sent_next = pong_sent_reg;
        res            = '0;
        finish         = 1'b0;
        hdr_done       = 1'b0;
        hdr_len        = left_reg;
        fbc_inc        = fbc_reg + 4'd1;
        left_shift     = {left_reg[55:0], rx_byte};
        left_dec       = left_reg - 64'd1;
        diff           = now_time - pong_t_reg;
        ext_full       = (slen_reg == wsfr_pkg::LEN_CODE_16) ?
                         (fbc_inc >= wsfr_pkg::EXT16_BYTES) :
                         (fbc_inc >= wsfr_pkg::EXT64_BYTES);

        unique case (midx_reg)
            2'd0: key_byte = key_reg[31:24];
            2'd1: key_byte = key_reg[23:16];
            2'd2: key_byte = key_reg[15:8];
            2'd3: key_byte = key_reg[7:0];
        endcase
        if (!mpres_reg) begin
            key_byte = 8'd0;
        end

        if (link_reg != wsfr_pkg::LINK_CLOSED) begin
            unique case (kind)
                wsfr_pkg::KIND_BYTE: begin
                    unique case (phase_reg)
                        wsfr_pkg::PH_HDR0: begin
                            fin_next   = rx_byte[7];
                            op_next    = rx_byte[3:0];
                            phase_next = wsfr_pkg::PH_HDR1;
                        end
                        wsfr_pkg::PH_HDR1: begin
                            mpres_next = rx_byte[7];
                            slen_next  = rx_byte[6:0];
                            key_next   = '0;
                            fbc_next   = '0;
                            if (rx_byte[6:0] == wsfr_pkg::LEN_CODE_16 ||
                                rx_byte[6:0] == wsfr_pkg::LEN_CODE_64) begin
                                left_next  = '0;
                                phase_next = wsfr_pkg::PH_EXT;
                            end else begin
                                left_next = {57'd0, rx_byte[6:0]};
                                hdr_len   = {57'd0, rx_byte[6:0]};
                                if (rx_byte[7]) begin
                                    phase_next = wsfr_pkg::PH_MASK;
                                end else begin
                                    hdr_done = 1'b1;
                                end
                            end
                        end
                        wsfr_pkg::PH_EXT: begin
                            left_next = left_shift;
                            hdr_len   = left_shift;
                            fbc_next  = fbc_inc;
                            if (ext_full) begin
                                fbc_next = '0;
                                if (mpres_reg) begin
                                    phase_next = wsfr_pkg::PH_MASK;
                                end else begin
                                    hdr_done = 1'b1;
                                end
                            end
                        end
                        wsfr_pkg::PH_MASK: begin
                            key_next = {key_reg[23:0], rx_byte};
                            fbc_next = fbc_inc;
                            if (fbc_inc >= wsfr_pkg::KEY_BYTES) begin
                                fbc_next = '0;
                                hdr_done = 1'b1;
                            end
                        end
                        wsfr_pkg::PH_PAYLOAD: begin
                            midx_next        = midx_reg + 2'd1;
                            res.payload_byte = rx_byte ^ key_byte;
                            if (op_reg == wsfr_pkg::OP_TEXT || op_reg == wsfr_pkg::OP_BIN) begin
                                res.byte_class = wsfr_pkg::CLS_DATA;
                            end else if (op_reg == wsfr_pkg::OP_PING) begin
                                res.byte_class = wsfr_pkg::CLS_PING;
                            end else begin
                                res.byte_class = wsfr_pkg::CLS_OTHER;
                            end
                            left_next = left_dec;
                            if (left_dec == 64'd0) begin
                                finish = 1'b1;
                            end
                        end
                        default: begin
                            phase_next = wsfr_pkg::PH_HDR0;
                        end
                    endcase
                end
                wsfr_pkg::KIND_TICK: begin
                    if (link_reg == wsfr_pkg::LINK_OPEN) begin
                        if (missed_reg >= max_missed) begin
                            res.want_close  = 1'b1;
                            res.link_closed = 1'b1;
                            link_next       = wsfr_pkg::LINK_CLOSED;
                        end else begin
                            missed_next   = missed_reg + 8'd1;
                            res.want_ping = 1'b1;
                        end
                    end
                end
                wsfr_pkg::KIND_CLOSE: begin
                    link_next      = wsfr_pkg::LINK_CLOSING;
                    res.want_close = 1'b1;
                end
                default: begin
                end
            endcase
        end

        if (hdr_done) begin
            slen_next = (hdr_len <= 64'd125) ? hdr_len[6:0] : wsfr_pkg::LONG_MARK;
            midx_next = '0;
            if (hdr_len == 64'd0) begin
                finish = 1'b1;
            end else begin
                phase_next = wsfr_pkg::PH_PAYLOAD;
            end
        end

        if (finish) begin
            res.frame_end = 1'b1;
            missed_next   = '0;
            if (op_reg == wsfr_pkg::OP_PING) begin
                if (!pong_sent_reg || (diff != 32'd0 && diff >= pong_gap)) begin
                    pong_t_next    = now_time;
                    pong_sent_next = 1'b1;
                    if (slen_next <= wsfr_pkg::MAX_CTRL_LEN) begin
                        res.want_pong = 1'b1;
                    end
                end
            end else if (op_reg == wsfr_pkg::OP_CLOSE) begin
                if (link_next == wsfr_pkg::LINK_OPEN) begin
                    res.want_close = 1'b1;
                end
                link_next       = wsfr_pkg::LINK_CLOSED;
                res.link_closed = 1'b1;
            end
            if ((!fin_reg || op_reg == wsfr_pkg::OP_CONT) &&
                link_next != wsfr_pkg::LINK_CLOSED) begin
                link_next      = wsfr_pkg::LINK_CLOSING;
                res.want_close = 1'b1;
            end
            phase_next = wsfr_pkg::PH_HDR0;
        end

        res.frame_opcode = op_next;
        res.link_state   = link_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= wsfr_pkg::PH_HDR0;
            link_reg      <= wsfr_pkg::LINK_OPEN;
            fbc_reg       <= '0;
            fin_reg       <= 1'b0;
            op_reg        <= '0;
            mpres_reg     <= 1'b0;
            key_reg       <= '0;
            left_reg      <= '0;
            slen_reg      <= '0;
            midx_reg      <= '0;
            missed_reg    <= '0;
            pong_t_reg    <= '0;
            pong_sent_reg <= 1'b0;
        end else if (en) begin
            phase_reg     <= phase_next;
            link_reg      <= link_next;
            fbc_reg       <= fbc_next;
            fin_reg       <= fin_next;
            op_reg        <= op_next;
            mpres_reg     <= mpres_next;
            key_reg       <= key_next;
            left_reg      <= left_next;
            slen_reg      <= slen_next;
            midx_reg      <= midx_next;
            missed_reg    <= missed_next;
            pong_t_reg    <= pong_t_next;
            pong_sent_reg <= pong_sent_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/websocket_frame_receiver.sv =====
`default_nettype none
// Channel   Direction  Handshake         Content
// s_        in         tvalid / tready   one request: rx byte, tick or host close
// m_        out        tvalid / tready   one result per request
// cfg_      in         cfg_wr_en         tick limit (0), pong gap (1)
//
// One request per clock unless m_ stalls; m_tvalid is driven by the output register.
// Path: input register -> frame parser / link logic -> output register.
// aresetn is synchronous; parser, link state and config registers reset.
// A stalled m_ side holds its result; s_ keeps accepting while the input
// register can move forward into a free or draining output register.
module websocket_frame_receiver (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // rx_byte[7:0], now_time[39:8]
    input  wire logic [1:0]  s_tuser,   // kind[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // payload_byte[7:0], frame_opcode[11:8],
                                        // want_ping[12], want_pong[13],
                                        // want_close[14], link_closed[15],
                                        // link_state[17:16], zero[23:18]
    output logic [1:0]       m_tuser,   // byte_class[1:0]
    output logic             m_tlast,   // frame_end
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_addr,
    input  wire logic [31:0] cfg_wdata
);

    logic           in_valid_reg;
    logic [1:0]     kind_reg;
    logic [7:0]     byte_reg;
    logic [31:0]    time_reg;
    logic           out_valid_reg;
    wsfr_pkg::res_t out_reg;
    wsfr_pkg::res_t res;
    logic [7:0]     max_missed_reg;
    logic [31:0]    pong_gap_reg;
    logic           advance;
    logic           take;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign take     = s_tvalid && s_tready;

    wsfr_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (advance),
        .kind       (kind_reg),
        .rx_byte    (byte_reg),
        .now_time   (time_reg),
        .max_missed (max_missed_reg),
        .pong_gap   (pong_gap_reg),
        .res        (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            max_missed_reg <= wsfr_pkg::MISSED_RESET;
            pong_gap_reg   <= wsfr_pkg::GAP_RESET;
        end else begin
            if (take) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    wsfr_pkg::CFG_MISSED: max_missed_reg <= cfg_wdata[7:0];
                    wsfr_pkg::CFG_GAP:    pong_gap_reg   <= cfg_wdata;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            kind_reg <= s_tuser;
            byte_reg <= s_tdata[7:0];
            time_reg <= s_tdata[39:8];
        end
        if (advance) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.byte_class;
    assign m_tlast  = out_reg.frame_end;
    assign m_tdata  = {6'd0, out_reg.link_state, out_reg.link_closed, out_reg.want_close,
                       out_reg.want_pong, out_reg.want_ping, out_reg.frame_opcode,
                       out_reg.payload_byte};

endmodule
`default_nettype wire
